@@ src/clsp_pkg.sv @@
package clsp_pkg;

  localparam int GW = 31;
  localparam int MW = 16;
  localparam int PW = GW + MW;

  localparam logic [GW:0]   MOD1  = 32'd2147483563;
  localparam logic [GW:0]   MOD2  = 32'd2147483399;
  localparam logic [GW:0]   WRAP1 = 32'd2147483562;
  localparam logic [MW-1:0] MUL1  = 16'd40014;
  localparam logic [MW-1:0] MUL2  = 16'd40692;
  localparam logic [7:0]    FOLD1 = 8'd85;
  localparam logic [7:0]    FOLD2 = 8'd249;
  localparam logic [GW-1:0] CLAMP_FROM = 31'd2147483306;

  localparam logic [0:0] REG_SEED = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_INIT_RED,
    OP_DRAW_RED,
    OP_READ,
    OP_WRITE
  } clsp_op_e;

  typedef struct packed {
    clsp_op_e op;
  } clsp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic out_free;
  } clsp_status_t;

endpackage

@@ src/clsp_ctrl.sv @@
module clsp_ctrl
  import clsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_reseed_i,
  output logic         in_ready_o,
  input  clsp_status_t status_i,
  output clsp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_IMUL = 3'd2;
  localparam logic [2:0] ST_IRED = 3'd3;
  localparam logic [2:0] ST_DMUL = 3'd4;
  localparam logic [2:0] ST_DRED = 3'd5;
  localparam logic [2:0] ST_DRD  = 3'd6;
  localparam logic [2:0] ST_DWR  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       needs_init_q, needs_init_d;

  always_comb begin
    state_d      = state_q;
    needs_init_d = needs_init_q;
    in_ready_o   = 1'b0;
    cmd_o.op     = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_reseed_i || needs_init_q) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DMUL;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = ST_IMUL;
      end
      ST_IMUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_IRED;
      end
      ST_IRED: begin
        cmd_o.op = OP_INIT_RED;
        if (status_i.init_last) begin
          needs_init_d = 1'b0;
          state_d      = ST_DMUL;
        end else begin
          state_d = ST_IMUL;
        end
      end
      ST_DMUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_DRED;
      end
      ST_DRED: begin
        cmd_o.op = OP_DRAW_RED;
        state_d  = ST_DRD;
      end
      ST_DRD: begin
        cmd_o.op = OP_READ;
        state_d  = ST_DWR;
      end
      ST_DWR: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_WRITE;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      needs_init_q <= 1'b1;
    end else begin
      state_q      <= state_d;
      needs_init_q <= needs_init_d;
    end
  end

endmodule

@@ src/clsp_dp.sv @@
module clsp_dp
  import clsp_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [GW-1:0] seed_i,
  input  clsp_cmd_t     cmd_i,
  output clsp_status_t  status_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [GW-1:0] out_value_o,
  output logic          out_clamped_o
);

  localparam int CW  = $clog2(TABLE_DEPTH + 8);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int QW  = $clog2(TABLE_DEPTH + 1);
  localparam int QPW = GW + QW;
  localparam longint unsigned SLOT_DIV = 64'(WRAP1) / TABLE_DEPTH + 64'd1;
  localparam longint unsigned RECIP    = (64'd1 << GW) / SLOT_DIV;
  localparam logic [QW-1:0]  RECIP_W  = QW'(RECIP);
  localparam logic [QPW-1:0] DIV_W    = QPW'(SLOT_DIV);
  localparam logic [QW-1:0]  SLOT_MAX = QW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0]  CNT_INIT = CW'(TABLE_DEPTH + 7);
  localparam logic [CW-1:0]  DEPTH_C  = CW'(TABLE_DEPTH);

  function automatic logic [GW-1:0] reduce(input logic [PW-1:0] p, input logic [7:0] fold,
                                           input logic [GW:0] modv);
    logic [GW:0] s;
    s = {1'b0, p[GW-1:0]} + (GW+1)'(p[PW-1:GW]) * (GW+1)'(fold);
    if (s >= modv) begin
      s = s - modv;
    end
    return s[GW-1:0];
  endfunction

  logic [GW-1:0]  g1_q, g2_q, last_q, rd_q;
  logic [PW-1:0]  p1_q, p2_q;
  logic [QW-1:0]  qe_q;
  logic [AW-1:0]  slot_q;
  logic [CW-1:0]  cnt_q;
  logic [GW-1:0]  mem [TABLE_DEPTH];
  logic           out_valid_q;
  logic [GW-1:0]  out_value_q;
  logic           out_clamped_q;

  logic [GW-1:0]  g1_red, g2_red, seed_eff;
  logic [QPW-1:0] qe_prod, q_back, rem;
  logic [QW-1:0]  q_fix, slot_sat;
  logic [GW:0]    y_full;
  logic [GW-1:0]  y;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [GW-1:0]  wdata;

  assign g1_red   = reduce(p1_q, FOLD1, MOD1);
  assign g2_red   = reduce(p2_q, FOLD2, MOD2);
  assign seed_eff = (seed_i == '0) ? GW'(1) : seed_i;

  assign qe_prod  = QPW'(last_q) * QPW'(RECIP_W);
  assign q_back   = QPW'(qe_q) * DIV_W;
  assign rem      = QPW'(last_q) - q_back;
  assign q_fix    = qe_q + QW'(rem >= DIV_W);
  assign slot_sat = (q_fix > SLOT_MAX) ? SLOT_MAX : q_fix;

  always_comb begin
    if (rd_q > g2_q) begin
      y_full = {1'b0, rd_q} - {1'b0, g2_q};
    end else begin
      y_full = WRAP1 - ({1'b0, g2_q} - {1'b0, rd_q});
    end
  end
  assign y = y_full[GW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = g1_q;
    if (cmd_i.op == OP_INIT_RED) begin
      we    = (cnt_q < DEPTH_C);
      waddr = cnt_q[AW-1:0];
      wdata = g1_red;
    end else if (cmd_i.op == OP_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.op == OP_READ) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        g1_q  <= seed_eff;
        g2_q  <= seed_eff;
        cnt_q <= CNT_INIT;
      end
      OP_MUL: begin
        p1_q <= PW'(g1_q) * PW'(MUL1);
        p2_q <= PW'(g2_q) * PW'(MUL2);
        qe_q <= qe_prod[QPW-1:GW];
      end
      OP_INIT_RED: begin
        g1_q  <= g1_red;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          last_q <= g1_red;
        end
      end
      OP_DRAW_RED: begin
        g1_q   <= g1_red;
        g2_q   <= g2_red;
        slot_q <= slot_sat[AW-1:0];
      end
      OP_WRITE: begin
        last_q        <= y;
        out_value_q   <= y;
        out_clamped_q <= (y >= CLAMP_FROM);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_WRITE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.init_last = (cnt_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_value_o        = out_value_q;
  assign out_clamped_o      = out_clamped_q;

endmodule

@@ src/combined_lcg_shuffle_prng_top.sv @@
// Combined congruential generator with a shuffle table.
// Each word accepted on the input stream requests one draw; bit 0 of its data
// asks for the generators and the table to be rebuilt from the seed register first.
// Each draw yields one output word: the value in tdata and the clamp flag in tuser.
// The user must write the seed register through the APB port only while the block
// is idle; the block itself does not enforce this. An ordinary draw runs the
// modular multiply, the reduce with the slot computation, and the table read and
// write before the output word is registered.
// The input is ready again in the cycle after the result is registered, so a new
// request is taken only once the previous draw is done. A rebuild loads both
// generators from the seed, then runs one multiply and reduce of the first generator per step.
// After reset the seed is 1, and the first draw always rebuilds the table.
// A finished word waits in the output register while the next request is taken
// and worked on; if the receiver still stalls, that draw holds before its
// table write until the register frees.
module combined_lcg_shuffle_prng_top
  import clsp_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] reseed, [7:1] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] value, [31] zero
  output logic [0:0]  m_axis_tuser_o,   // [0] clamped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GW-1:0] seed_q;
  clsp_cmd_t     cmd;
  clsp_status_t  status;
  logic [GW-1:0] out_value;
  logic          out_clamped;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= GW'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEED)) begin
      seed_q <= pwdata[GW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SEED) ? {1'b0, seed_q} : '0;

  clsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_reseed_i (s_axis_tdata_i[0]),
    .in_ready_o  (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clsp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_value_o   (out_value),
    .out_clamped_o (out_clamped)
  );

  assign m_axis_tdata_o = {1'b0, out_value};
  assign m_axis_tuser_o = out_clamped;

  a_write_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_WRITE) |-> status.out_free)
    else $error("draw completed while the output register was still occupied");

  a_valid_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.op == OP_WRITE))
    else $error("output word appeared without a completed draw");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (cmd.op == OP_NONE))
    else $error("datapath commanded while waiting for a request");

endmodule
